// ===== rtl/gradient_colormap_lookup_assert.svh =====
// Assertion macros shared by the gradient colormap RTL.
`ifndef GRADIENT_COLORMAP_LOOKUP_ASSERT_SVH
`define GRADIENT_COLORMAP_LOOKUP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define GCL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcl: same-cycle check failed");
// Next-cycle implication, disabled while reset is high.
`define GCL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcl: next-cycle check failed");
`else
`define GCL_ASSERT_IMP(label, clk, rst, ante, cons)
`define GCL_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/gcl_pkg.sv =====
package gcl_pkg;

  localparam int POS_BITS = 16;
  localparam int CH_BITS  = 8;
  localparam int STEP_W   = $clog2(POS_BITS);
  localparam int CFG_W    = 5;
  localparam int IDX_W    = 4;

  // Item kinds carried in tuser
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Channel select codes for the interpolation step
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef struct packed {
    logic [CH_BITS-1:0]  blue;
    logic [CH_BITS-1:0]  green;
    logic [CH_BITS-1:0]  red;
    logic [POS_BITS-1:0] pos;
  } stop_t;

  typedef struct packed {
    logic       cmp_en;
    logic       cmp_first;
    logic       decide;
    logic       div_step;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic edge_hit;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/gcl_ram.sv =====
module gcl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gcl_ctrl.sv =====
`include "gradient_colormap_lookup_assert.svh"

module gcl_ctrl #(
  parameter int MAX_STOPS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           lookup_start,
  input  logic [$clog2(MAX_STOPS+1)-1:0] n_live,
  input  gcl_pkg::dp_status_t            status,
  output gcl_pkg::ctrl_cmd_t             cmd,
  output logic                           ram_re,
  output logic [$clog2(MAX_STOPS)-1:0]   ram_raddr,
  output logic                           ready
);
  import gcl_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;

  logic [2:0]        state, state_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [STEP_W-1:0] step, step_next;
  logic [1:0]        ch, ch_next;
  logic              rd_pend, rd_first;
  logic              scan_last;

  assign scan_last = (32'(cnt) + 32'd1) >= 32'(n_live);
  assign ready     = (state == S_IDLE);
  assign ram_re    = (state == S_SCAN);
  assign ram_raddr = cnt[AW-1:0];

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    step_next     = step;
    ch_next       = ch;
    cmd           = '0;
    cmd.cmp_en    = rd_pend;
    cmd.cmp_first = rd_first;
    cmd.mul_sel   = ch;
    case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (lookup_start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        step_next  = '0;
        state_next = status.edge_hit ? S_LOAD : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + STEP_W'(1);
        if (step == STEP_W'(POS_BITS - 1)) begin
          state_next = S_MUL;
          ch_next    = CH_RED;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (ch == CH_BLUE) begin
          state_next = S_LOAD;
        end else begin
          ch_next = ch + 2'd1;
        end
      end
      S_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      step     <= '0;
      ch       <= CH_RED;
      rd_pend  <= 1'b0;
      rd_first <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      step     <= step_next;
      ch       <= ch_next;
      rd_pend  <= (state == S_SCAN);
      rd_first <= (state == S_SCAN) && (cnt == '0);
    end
  end

  `GCL_ASSERT_NXT(a_start_scan, clk, rst, ready && lookup_start, state == S_SCAN)
  `GCL_ASSERT_IMP(a_load_free, clk, rst, cmd.load_out, status.out_free)
  `GCL_ASSERT_IMP(a_scan_bound, clk, rst, state == S_SCAN, 32'(cnt) < 32'(n_live))

endmodule

// ===== rtl/gcl_datapath.sv =====
`include "gradient_colormap_lookup_assert.svh"

module gcl_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             latch_sample,
  input  logic [gcl_pkg::POS_BITS-1:0]     sample_in,
  input  gcl_pkg::stop_t                   rdata,
  input  gcl_pkg::ctrl_cmd_t               cmd,
  output gcl_pkg::dp_status_t              status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [3*gcl_pkg::CH_BITS-1:0]    out_rgb
);
  import gcl_pkg::*;

  localparam int PW = CH_BITS + POS_BITS + 1;
  localparam logic [POS_BITS:0] ONE_T = (POS_BITS+1)'(1) << POS_BITS;
  localparam logic [PW-1:0]     HALF  = PW'(1) << (POS_BITS - 1);

  stop_t               lo, hi, ea, eb;
  logic                have_a, have_b;
  logic [POS_BITS-1:0] sample_q;
  logic [POS_BITS:0]   rem;
  logic [POS_BITS-1:0] quo;
  logic                q_int;
  logic [CH_BITS-1:0]  res_r, res_g, res_b;

  logic                below, have_a_eff, have_b_eff;
  logic                edge_lo, edge_hi;
  logic [POS_BITS-1:0] den, num;
  logic [POS_BITS:0]   rem2, t, t_inv;
  logic                ge;
  logic [CH_BITS-1:0]  ca, cb;
  logic [PW-1:0]       v;

  assign below      = rdata.pos < sample_q;
  assign have_a_eff = have_a & ~cmd.cmp_first;
  assign have_b_eff = have_b & ~cmd.cmp_first;
  assign edge_lo    = sample_q <= lo.pos;
  assign edge_hi    = sample_q >= hi.pos;
  assign den        = eb.pos - ea.pos;
  assign num        = sample_q - ea.pos;
  assign rem2       = {rem[POS_BITS-1:0], 1'b0};
  assign ge         = rem2 >= {1'b0, den};
  assign t          = {q_int, quo};
  assign t_inv      = ONE_T - t;

  always_comb begin
    case (cmd.mul_sel)
      CH_RED:   begin ca = ea.red;   cb = eb.red;   end
      CH_GREEN: begin ca = ea.green; cb = eb.green; end
      CH_BLUE:  begin ca = ea.blue;  cb = eb.blue;  end
      default:  begin ca = ea.red;   cb = eb.red;   end
    endcase
  end

  // Blend: cA*(1-t) + cB*t, rounded half up
  assign v = PW'(ca) * PW'(t_inv) + PW'(cb) * PW'(t) + HALF;

  assign status.edge_hit = edge_lo | edge_hi;
  assign status.out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (latch_sample) begin
      sample_q <= sample_in;
    end
    if (cmd.cmp_en) begin
      if (cmd.cmp_first || rdata.pos < lo.pos) begin
        lo <= rdata;
      end
      if (cmd.cmp_first || rdata.pos > hi.pos) begin
        hi <= rdata;
      end
      if (below && (!have_a_eff || rdata.pos > ea.pos)) begin
        ea <= rdata;
      end
      if (!below && (!have_b_eff || rdata.pos < eb.pos)) begin
        eb <= rdata;
      end
    end
    if (cmd.decide) begin
      if (edge_lo) begin
        res_r <= lo.red;
        res_g <= lo.green;
        res_b <= lo.blue;
      end else if (edge_hi) begin
        res_r <= hi.red;
        res_g <= hi.green;
        res_b <= hi.blue;
      end
      q_int <= (num == den);
      rem   <= (num == den) ? '0 : {1'b0, num};
      quo   <= '0;
    end
    if (cmd.div_step) begin
      if (ge) begin
        rem <= rem2 - {1'b0, den};
        quo <= {quo[POS_BITS-2:0], 1'b1};
      end else begin
        rem <= rem2;
        quo <= {quo[POS_BITS-2:0], 1'b0};
      end
    end
    if (cmd.mul_step) begin
      case (cmd.mul_sel)
        CH_RED:   res_r <= v[POS_BITS +: CH_BITS];
        CH_GREEN: res_g <= v[POS_BITS +: CH_BITS];
        CH_BLUE:  res_b <= v[POS_BITS +: CH_BITS];
        default:  res_r <= v[POS_BITS +: CH_BITS];
      endcase
    end
    if (cmd.load_out) begin
      out_rgb <= {res_b, res_g, res_r};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have_a    <= 1'b0;
      have_b    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.cmp_en) begin
        have_a <= have_a_eff | below;
        have_b <= have_b_eff | ~below;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `GCL_ASSERT_IMP(a_div_span, clk, rst, cmd.div_step, den != '0 && ea.pos < sample_q)

endmodule

// ===== rtl/gradient_colormap_lookup.sv =====
// Channel  | Dir | Signals                          | Carries
// ---------+-----+----------------------------------+--------------------------------
// s_axis   | in  | tvalid tready tdata[63:0] tuser  | stop write or sample lookup
// m_axis   | out | tvalid tready tdata[23:0]        | looked-up RGB color
// cfg      | in  | cfg_we cfg_wdata[4:0]            | stops_in_use register
//
// A stop write lands in the stop RAM on the accepting beat.
// A lookup makes one RAM read per stop (n being the live stop count), runs a
// 16-step restoring divider for t, then blends one channel per cycle before it
// loads the result. Lookups that hit an end stop skip the divide and the blend.
// Reset sets stops_in_use to 2 and clears control state; the RAM holds garbage until
// written. A result waiting in the output register does not block the next beat;
// only loading a new result waits for it to drain.
module gradient_colormap_lookup #(
  parameter int MAX_STOPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] stop_index, [19:4] stop_position, [27:20] stop_red, [35:28] stop_green,
  // [43:36] stop_blue, [59:44] sample, [63:60] zero
  input  logic [63:0] s_axis_tdata,
  // [0] cmd (0 write stop, 1 lookup)
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  import gcl_pkg::*;

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = $clog2(MAX_STOPS + 1);

  logic [CFG_W-1:0]    stops_in_use;
  logic [CW-1:0]       n_live;
  logic                accept, lookup_start, wr_en;
  logic [IDX_W-1:0]    stop_index;
  logic [31:0]         idx_wide;
  stop_t               wr_stop, rd_stop;
  logic [$bits(stop_t)-1:0] rd_word;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  ctrl_cmd_t           cmd;
  dp_status_t          status;
  logic                ready;

  // Unpack the input beat
  assign stop_index    = s_axis_tdata[3:0];
  assign wr_stop.pos   = s_axis_tdata[19:4];
  assign wr_stop.red   = s_axis_tdata[27:20];
  assign wr_stop.green = s_axis_tdata[35:28];
  assign wr_stop.blue  = s_axis_tdata[43:36];
  assign idx_wide      = 32'(stop_index);

  assign s_axis_tready = ready;
  assign accept        = s_axis_tvalid & ready;
  assign lookup_start  = accept & (s_axis_tuser == CMD_LOOKUP);
  // Drop writes aimed past the end of the table
  assign wr_en         = accept & (s_axis_tuser == CMD_WRITE) & (idx_wide < 32'(MAX_STOPS));
  assign rd_stop       = stop_t'(rd_word);

  // Live stop count: zero counts as one, anything above the table size saturates
  always_comb begin
    if (stops_in_use == '0) begin
      n_live = CW'(1);
    end else if (32'(stops_in_use) > 32'(MAX_STOPS)) begin
      n_live = CW'(MAX_STOPS);
    end else begin
      n_live = CW'(stops_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stops_in_use <= CFG_W'(2);
    end else if (cfg_we) begin
      stops_in_use <= cfg_wdata;
    end
  end

  gcl_ram #(
    .WIDTH ($bits(stop_t)),
    .DEPTH (MAX_STOPS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx_wide[AW-1:0]),
    .wdata (wr_stop),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  gcl_ctrl #(
    .MAX_STOPS (MAX_STOPS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .lookup_start (lookup_start),
    .n_live       (n_live),
    .status       (status),
    .cmd          (cmd),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ready        (ready)
  );

  gcl_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .latch_sample (lookup_start),
    .sample_in    (s_axis_tdata[59:44]),
    .rdata        (rd_stop),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_rgb      (m_axis_tdata)
  );

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gcl_pkg::*;

  localparam int NUM_STOPS     = 16;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 110;
  localparam int IDLE_PCT      = 36;
  localparam int QUIET_PHASE   = 6;
  localparam int REPORT_LIMIT  = 10;
  // Let a lookup over 16 stops finish before touching the register or calling
  // the run done.
  localparam int SETTLE_CYCLES = 64;
  localparam int TAIL_CYCLES   = 100;
  localparam int LIMIT_NS      = 5_000_000;

  // Packed so that red lands in the low byte, as on m_axis_tdata.
  typedef struct packed {
    logic [CH_BITS-1:0] blue;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] red;
  } rgb_t;

  typedef struct packed {
    rgb_t                color;
    logic [POS_BITS-1:0] pos;
  } stop_rec_t;

  typedef enum logic {ROW_BEAT, ROW_COUNT} row_kind_t;

  // One row of the directed plan: either a beat on s_axis or a write of the
  // stop count. A lookup row may carry its color typed in (typed = 1).
  typedef struct {
    row_kind_t           kind;
    logic                cmd;
    logic [IDX_W-1:0]    idx;
    logic [POS_BITS-1:0] pos;
    rgb_t                color;
    logic [POS_BITS-1:0] sample;
    logic [CFG_W-1:0]    count;
    bit                  typed;
    rgb_t                want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = CMD_WRITE;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                cfg_we = 1'b0;
  logic [CFG_W-1:0]    cfg_wdata = '0;

  // Shadow of the block: stop table, stop count, colors still owed.
  stop_rec_t           stop_mem [NUM_STOPS];
  logic [CFG_W-1:0]    stops_cfg = 5'd2;
  rgb_t                expected_colors [$];
  plan_row_t           plan [$];
  int                  mismatches = 0;
  // Set for one whole phase: neither side idles.
  bit                  quiet = 1'b0;

  gradient_colormap_lookup #(
    .MAX_STOPS(NUM_STOPS)
  ) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic rgb_t rgb(logic [CH_BITS-1:0] r, logic [CH_BITS-1:0] g,
                               logic [CH_BITS-1:0] b);
    rgb_t c;
    c.red   = r;
    c.green = g;
    c.blue  = b;
    return c;
  endfunction

  // Zero count reads as one stop; anything past the table saturates.
  function automatic int live_stops();
    if (stops_cfg == 0) return 1;
    if (stops_cfg > NUM_STOPS) return NUM_STOPS;
    return int'(stops_cfg);
  endfunction

  // Weighted mix of two channels, rounded to nearest with ties going up.
  function automatic logic [CH_BITS-1:0] blend(logic [CH_BITS-1:0] ca,
                                               logic [CH_BITS-1:0] cb,
                                               longint unsigned t);
    longint unsigned one;
    longint unsigned v;
    one = 64'd1 << POS_BITS;
    v = 64'(ca) * (one - t) + 64'(cb) * t + (one >> 1);
    return CH_BITS'(v >> POS_BITS);
  endfunction

  // Color the block should return for a sample, given the live stops.
  function automatic rgb_t gradient_color(logic [POS_BITS-1:0] s);
    int              n;
    int              lo;
    int              hi;
    int              a;
    int              b;
    bit              have_a;
    bit              have_b;
    longint unsigned one;
    longint unsigned den;
    longint unsigned t;
    rgb_t            res;
    n = live_stops();
    lo = 0;
    hi = 0;
    a = 0;
    b = 0;
    have_a = 1'b0;
    have_b = 1'b0;
    one = 64'd1 << POS_BITS;
    // Strict compares keep the lowest index on equal positions.
    for (int i = 1; i < n; i++) begin
      if (stop_mem[i].pos < stop_mem[lo].pos) lo = i;
      if (stop_mem[i].pos > stop_mem[hi].pos) hi = i;
    end
    if (s <= stop_mem[lo].pos) return stop_mem[lo].color;
    if (s >= stop_mem[hi].pos) return stop_mem[hi].color;
    // Stop below the sample (closest) and stop at or above it (closest).
    for (int i = 0; i < n; i++) begin
      if (stop_mem[i].pos < s) begin
        if (!have_a || stop_mem[i].pos > stop_mem[a].pos) begin
          a = i;
          have_a = 1'b1;
        end
      end else begin
        if (!have_b || stop_mem[i].pos < stop_mem[b].pos) begin
          b = i;
          have_b = 1'b1;
        end
      end
    end
    den = 64'(stop_mem[b].pos) - 64'(stop_mem[a].pos);
    if (den == 0) den = 1;
    t = ((64'(s) - 64'(stop_mem[a].pos)) << POS_BITS) / den;
    if (t > one) t = one;
    res.red   = blend(stop_mem[a].color.red,   stop_mem[b].color.red,   t);
    res.green = blend(stop_mem[a].color.green, stop_mem[b].color.green, t);
    res.blue  = blend(stop_mem[a].color.blue,  stop_mem[b].color.blue,  t);
    return res;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, what);
  endfunction

  // Favor the channel extremes so that the rounding edges get hit.
  function automatic logic [CH_BITS-1:0] pick_channel();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return CH_BITS'($urandom());
  endfunction

  function automatic void plan_stop(logic [IDX_W-1:0] idx, logic [POS_BITS-1:0] pos,
                                    rgb_t color, logic [POS_BITS-1:0] sample);
    plan_row_t r;
    r = '{kind: ROW_BEAT, cmd: CMD_WRITE, idx: idx, pos: pos, color: color,
          sample: sample, count: '0, typed: 1'b0, want: '0};
    plan = {plan, r};
  endfunction

  // Lookup rows carry all-ones stop fields; the block has to ignore them.
  function automatic void plan_lookup(logic [POS_BITS-1:0] sample, bit typed, rgb_t want);
    plan_row_t r;
    r = '{kind: ROW_BEAT, cmd: CMD_LOOKUP, idx: '1, pos: '1, color: '1,
          sample: sample, count: '0, typed: typed, want: want};
    plan = {plan, r};
  endfunction

  function automatic void plan_count(logic [CFG_W-1:0] n);
    plan_row_t r;
    r = '{kind: ROW_COUNT, cmd: CMD_WRITE, idx: '0, pos: '0, color: '0,
          sample: '0, count: n, typed: 1'b0, want: '0};
    plan = {plan, r};
  endfunction

  // Drive one beat on s_axis, holding it until accepted, then update the
  // shadow table or queue the color owed. Random idle cycles go in front.
  task automatic send_beat(logic cmd, logic [IDX_W-1:0] idx, logic [POS_BITS-1:0] pos,
                           rgb_t color, logic [POS_BITS-1:0] sample, bit typed,
                           rgb_t want);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {4'd0, sample, color, pos, idx};
    do @(posedge clk); while (!s_axis_tready);
    if (cmd == CMD_WRITE) begin
      stop_mem[idx].pos   = pos;
      stop_mem[idx].color = color;
    end else begin
      expected_colors = {expected_colors, (typed ? want : gradient_color(sample))};
    end
  endtask

  // Drop valid and hold off until every owed color has come back.
  task automatic drain_results();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // Write the stop count only once the block is idle: drain, then let a
  // trailing stop write or lookup finish before the register moves.
  task automatic write_count(logic [CFG_W-1:0] n);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wdata <= n;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    stops_cfg = n;
  endtask

  // One random beat. Positions and samples lean toward live stop positions,
  // their neighbors and the range ends, so ties, end clamps and short spans
  // between stops come up often.
  task automatic random_item();
    int                  n;
    int                  j;
    int                  pick;
    logic [IDX_W-1:0]    idx;
    logic [POS_BITS-1:0] pos;
    logic [POS_BITS-1:0] sample;
    n = live_stops();
    j = $urandom_range(n - 1);
    pick = $urandom_range(99);
    if ($urandom_range(99) < 25) begin
      // Mostly rewrite a live stop; sometimes any index in the table.
      if ($urandom_range(99) < 70) idx = IDX_W'($urandom_range(n - 1));
      else idx = IDX_W'($urandom_range(NUM_STOPS - 1));
      if (pick < 15) pos = stop_mem[j].pos;
      else if (pick < 30) pos = $urandom_range(1) ? '1 : '0;
      else if (pick < 50) pos = $urandom_range(1) ?
                                stop_mem[j].pos + POS_BITS'($urandom_range(1, 4)) :
                                stop_mem[j].pos - POS_BITS'($urandom_range(1, 4));
      else pos = POS_BITS'($urandom());
      send_beat(CMD_WRITE, idx, pos, rgb(pick_channel(), pick_channel(), pick_channel()),
                POS_BITS'($urandom()), 1'b0, '0);
    end else begin
      if (pick < 25) sample = stop_mem[j].pos;
      else if (pick < 40) sample = $urandom_range(1) ? stop_mem[j].pos + 1'b1 :
                                                       stop_mem[j].pos - 1'b1;
      else if (pick < 50) sample = $urandom_range(1) ? '1 : '0;
      else sample = POS_BITS'($urandom());
      send_beat(CMD_LOOKUP, IDX_W'($urandom()), POS_BITS'($urandom()),
                rgb_t'(24'($urandom())), sample, 1'b0, '0);
    end
  endtask

  // Receiver: stall at random except in the quiet phase.
  always @(negedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each accepted color beat with the oldest one owed.
  always @(posedge clk) begin : check_colors
    rgb_t got;
    rgb_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = rgb_t'(m_axis_tdata);
      if (expected_colors.size() == 0) begin
        flag_mismatch($sformatf("color beat %h with none owed", got));
      end else begin
        want = expected_colors.pop_front();
        if (got.red != want.red)
          flag_mismatch($sformatf("red: expected %0d, got %0d", want.red, got.red));
        if (got.green != want.green)
          flag_mismatch($sformatf("green: expected %0d, got %0d", want.green, got.green));
        if (got.blue != want.blue)
          flag_mismatch($sformatf("blue: expected %0d, got %0d", want.blue, got.blue));
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] phase_counts [PHASES];
    logic [CFG_W-1:0] live_cfg;

    // Directed plan. Reset leaves two live stops, so load 0 and 1 first.
    plan_stop(4'd0, 16'h0000, rgb(8'h00, 8'h00, 8'h00), 16'hFFFF);
    plan_stop(4'd1, 16'hFFFF, rgb(8'hFF, 8'hFF, 8'hFF), 16'h0000);
    plan_lookup(16'h0000, 1'b1, rgb(8'h00, 8'h00, 8'h00));
    plan_lookup(16'hFFFF, 1'b1, rgb(8'hFF, 8'hFF, 8'hFF));
    plan_lookup(16'h8000, 1'b0, '0);
    plan_lookup(16'h0001, 1'b0, '0);
    plan_lookup(16'hFFFE, 1'b0, '0);
    // Top index, outside the live set: must not disturb lookups.
    plan_stop(4'd15, 16'hAAAA, rgb(8'h55, 8'hAA, 8'h0F), 16'h5555);
    // Two stops on the same position: index 0 wins every selection.
    plan_stop(4'd0, 16'h4000, rgb(8'hAA, 8'h55, 8'h0F), 16'h0000);
    plan_stop(4'd1, 16'h4000, rgb(8'h11, 8'h22, 8'h33), 16'h0000);
    plan_lookup(16'h4000, 1'b1, rgb(8'hAA, 8'h55, 8'h0F));
    plan_lookup(16'h3FFF, 1'b1, rgb(8'hAA, 8'h55, 8'h0F));
    plan_lookup(16'h4001, 1'b1, rgb(8'hAA, 8'h55, 8'h0F));
    // Zero count behaves as a single stop.
    plan_count(5'd0);
    plan_lookup(16'h0000, 1'b1, rgb(8'hAA, 8'h55, 8'h0F));
    plan_lookup(16'hFFFF, 1'b1, rgb(8'hAA, 8'h55, 8'h0F));
    // Stops stored high-to-low: the scan, not the index order, decides.
    plan_count(5'd2);
    plan_stop(4'd0, 16'hFFFF, rgb(8'hFF, 8'h00, 8'h80), 16'h0000);
    plan_stop(4'd1, 16'h0000, rgb(8'h00, 8'hFF, 8'h7F), 16'h0000);
    plan_lookup(16'h8000, 1'b0, '0);
    plan_lookup(16'h0001, 1'b0, '0);
    plan_lookup(16'h0000, 1'b1, rgb(8'h00, 8'hFF, 8'h7F));
    plan_lookup(16'hFFFF, 1'b1, rgb(8'hFF, 8'h00, 8'h80));

    // Extremes and saturating values first, then two random settings.
    phase_counts = '{5'd16, 5'd31, 5'd1, 5'd0, 5'd17, 5'd2, 5'd3, 5'd8, 5'd0, 5'd0};
    phase_counts[8] = CFG_W'($urandom_range(31));
    phase_counts[9] = CFG_W'($urandom_range(4, 15));

    // Hold reset, then release it on a falling edge.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_COUNT) begin
        write_count(plan[i].count);
      end else begin
        send_beat(plan[i].cmd, plan[i].idx, plan[i].pos, plan[i].color, plan[i].sample,
                  plan[i].typed, plan[i].want);
      end
    end

    // Load every entry so any stop count reads only written stops.
    for (int i = 0; i < NUM_STOPS; i++) begin
      send_beat(CMD_WRITE, IDX_W'(i), POS_BITS'($urandom()),
                rgb(pick_channel(), pick_channel(), pick_channel()),
                POS_BITS'($urandom()), 1'b0, '0);
    end

    for (int p = 0; p < PHASES; p++) begin
      live_cfg = phase_counts[p];
      write_count(live_cfg);
      quiet = (p == QUIET_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // Halfway through, pause the sender until the output side is empty.
        if (k == PHASE_ITEMS / 2) drain_results();
        random_item();
      end
    end
    quiet = 1'b0;

    // Collect what is still owed, then watch for stray beats.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_colors.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard stop if the handshakes hang.
  initial begin : watchdog
    #LIMIT_NS;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/gcl_pkg.sv
rtl/gcl_ram.sv
rtl/gcl_ctrl.sv
rtl/gcl_datapath.sv
rtl/gradient_colormap_lookup.sv
tb/sv/testbench.sv
